// File: design/vfd_pkg.sv
`default_nettype none

package vfd_pkg;

   // widths of the stream fields
   localparam int ByteWidth  = 8;
   localparam int KindWidth  = 2;
   localparam int SigWidth   = 24;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = SigWidth;

   // payload buffer depth default
   localparam int PayloadMaxDefault = 7;

   // payload sizes per frame type
   localparam int SizeMarker = 3;
   localparam int SizeV6     = 6;
   localparam int SizeV7     = 7;

   // register reset values
   localparam logic [SigWidth-1:0]  SigReset      = '0;
   localparam logic [ByteWidth-1:0] CodeBeginReset = 8'd0;
   localparam logic [ByteWidth-1:0] CodeEndReset   = 8'd1;
   localparam logic [ByteWidth-1:0] Code1200Reset  = 8'd2;
   localparam logic [ByteWidth-1:0] Code2400Reset  = 8'd3;
   localparam logic [ByteWidth-1:0] Code1400Reset  = 8'd4;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SIGNATURE  = 3'd0,
      CSR_CODE_BEGIN = 3'd1,
      CSR_CODE_END   = 3'd2,
      CSR_CODE_1200  = 3'd3,
      CSR_CODE_2400  = 3'd4,
      CSR_CODE_1400  = 3'd5,
      CSR_STRICT     = 3'd6
   } csr_index_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_1200 = 2'd0,
      KIND_2400 = 2'd1,
      KIND_1400 = 2'd2
   } voice_kind_type;

endpackage

`default_nettype wire

// File: design/vfd_if.sv
`default_nettype none

// byte request channel
interface vfd_req_if import vfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// voice byte response channel
interface vfd_rsp_if import vfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 last_of_frame;
   logic [KindWidth-1:0] voice_kind;

   modport source (output valid, output out_byte, output last_of_frame,
                   output voice_kind, input ready);
   modport sink   (input valid, input out_byte, input last_of_frame,
                   input voice_kind, output ready);
endinterface

`default_nettype wire

// File: design/voice_frame_deframer_core.sv
// channel   | dir | handshake          | payload
// req_if    | in  | valid / ready      | in_byte
// rsp_if    | out | valid / ready      | out_byte, last_of_frame, voice_kind
// csr_*     | in  | csr_we, no ready   | csr_index, csr_wdata
//
// header and payload bytes are accepted while req_if.ready stays high
// a voice frame then drains from the payload ram byte by byte:
// one ram read and one output register load per byte, requests held off meanwhile
// a stalled rsp_if stretches the drain, one ram read is in flight at most
// reset is synchronous and clears the control flags and indices, the ram needs no clearing pass
`default_nettype none

module voice_frame_deframer_core import vfd_pkg::*; #(
   parameter int PayloadMax = PayloadMaxDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   vfd_req_if.sink                      req_if,
   vfd_rsp_if.source                    rsp_if,
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   // ram address and byte count widths
   localparam int AW = $clog2(PayloadMax);
   localparam int CW = $clog2(PayloadMax + 1);

   localparam logic [CW-1:0] CntMarker = CW'(SizeMarker);
   localparam logic [CW-1:0] CntV6     = CW'(SizeV6);
   localparam logic [CW-1:0] CntV7     = CW'(SizeV7);

   typedef enum logic {
      ST_TAKE,
      ST_EMIT
   } state_type;

   // configuration registers
   logic [SigWidth-1:0]  sig_ff;
   logic [ByteWidth-1:0] code_begin_ff, code_end_ff;
   logic [ByteWidth-1:0] code_1200_ff, code_2400_ff, code_1400_ff;
   logic                 strict_ff;

   // control state
   state_type     state_ff, state_in;
   logic [31:0]   hdr_ff, hdr_in;
   logic [2:0]    fill_ff, fill_in;
   logic          in_pay_ff, in_pay_in;
   logic          open_ff, open_in;
   logic [CW-1:0] size_ff, size_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [KindWidth-1:0] kind_ff, kind_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic [KindWidth-1:0] pend_kind_ff, pend_kind_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0] out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic [KindWidth-1:0] out_kind_ff, out_kind_in;

   logic                 req_take;
   logic                 ram_we;
   logic                 ram_re;
   logic [ByteWidth-1:0] ram_rdata;
   logic [31:0]          win;
   logic [ByteWidth-1:0] frame_type;
   logic [ByteWidth-1:0] hdr_type;
   logic                 is_voice;
   logic [KindWidth-1:0] voice_code;
   logic                 do_emit;
   logic [CW-1:0]        wr_cnt;
   logic [CW-1:0]        rd_cnt;

   assign req_if.ready = (state_ff == ST_TAKE);
   assign req_take     = req_if.valid && req_if.ready;
   assign ram_we       = req_take && in_pay_ff;

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.out_byte      = out_byte_ff;
   assign rsp_if.last_of_frame = out_last_ff;
   assign rsp_if.voice_kind    = out_kind_ff;

   // window with the new byte shifted in
   assign win        = {hdr_ff[23:0], req_if.in_byte};
   assign hdr_type   = win[7:0];
   // type byte of the frame in progress
   assign frame_type = hdr_ff[7:0];

   assign wr_cnt = CW'(wr_idx_ff) + CW'(1);
   assign rd_cnt = CW'(rd_idx_ff) + CW'(1);

   // voice test, first match wins in 1200, 2400, 1400 order
   always_comb begin
      is_voice   = 1'b1;
      voice_code = KIND_1200;
      if (frame_type == code_1200_ff) begin
         voice_code = KIND_1200;
      end else if (frame_type == code_2400_ff) begin
         voice_code = KIND_2400;
      end else if (frame_type == code_1400_ff) begin
         voice_code = KIND_1400;
      end else begin
         is_voice = 1'b0;
      end
   end

   // emit decision and stream gating at the end of a payload
   always_comb begin
      do_emit = 1'b0;
      open_in = open_ff;
      if (ram_we && (wr_cnt == size_ff)) begin
         if (!strict_ff) begin
            do_emit = is_voice;
         end else if (!open_ff) begin
            if (frame_type == code_begin_ff) begin
               open_in = 1'b1;
            end
         end else if (is_voice) begin
            do_emit = 1'b1;
         end else if (frame_type == code_end_ff) begin
            open_in = 1'b0;
         end
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      hdr_in       = hdr_ff;
      fill_in      = fill_ff;
      in_pay_in    = in_pay_ff;
      size_in      = size_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      kind_in      = kind_ff;
      ram_re       = 1'b0;
      pend_last_in = pend_last_ff;
      pend_kind_in = pend_kind_ff;

      case (state_ff)
         ST_TAKE: begin
            if (req_take && in_pay_ff) begin
               // payload byte goes to the ram
               wr_idx_in = wr_idx_ff + AW'(1);
               if (wr_cnt == size_ff) begin
                  in_pay_in = 1'b0;
                  if (do_emit) begin
                     state_in  = ST_EMIT;
                     rd_idx_in = '0;
                     kind_in   = voice_code;
                  end
               end
            end else if (req_take) begin
               // header collection, window slides on mismatch
               hdr_in  = win;
               fill_in = fill_ff + 3'd1;
               if (fill_ff == 3'd3) begin
                  if (win[31:8] != sig_ff) begin
                     fill_in = 3'd3;
                  end else begin
                     fill_in   = 3'd0;
                     wr_idx_in = '0;
                     in_pay_in = 1'b1;
                     if (hdr_type == code_begin_ff || hdr_type == code_end_ff) begin
                        size_in = CntMarker;
                     end else if (hdr_type == code_1400_ff) begin
                        size_in = CntV7;
                     end else if (hdr_type == code_1200_ff || hdr_type == code_2400_ff) begin
                        size_in = CntV6;
                     end else begin
                        // unknown type, drop header
                        in_pay_in = 1'b0;
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            // one read in flight, issued only when the output slot frees up
            if (!pend_ff && (!out_valid_ff || rsp_if.ready)) begin
               ram_re       = 1'b1;
               rd_idx_in    = rd_idx_ff + AW'(1);
               pend_last_in = (rd_cnt == size_ff);
               pend_kind_in = kind_ff;
               if (rd_cnt == size_ff) begin
                  state_in = ST_TAKE;
               end
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   assign pend_in = ram_re;

   // output register, loaded from the ram the cycle after a read
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_kind_in  = out_kind_ff;
      if (pend_ff) begin
         out_valid_in = 1'b1;
         out_byte_in  = ram_rdata;
         out_last_in  = pend_last_ff;
         out_kind_in  = pend_kind_ff;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TAKE;
         hdr_ff       <= '0;
         fill_ff      <= '0;
         in_pay_ff    <= 1'b0;
         open_ff      <= 1'b0;
         size_ff      <= '0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_ff       <= hdr_in;
         fill_ff      <= fill_in;
         in_pay_ff    <= in_pay_in;
         open_ff      <= open_in;
         size_ff      <= size_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff      <= kind_in;
      pend_last_ff <= pend_last_in;
      pend_kind_ff <= pend_kind_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_kind_ff  <= out_kind_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff        <= SigReset;
         code_begin_ff <= CodeBeginReset;
         code_end_ff   <= CodeEndReset;
         code_1200_ff  <= Code1200Reset;
         code_2400_ff  <= Code2400Reset;
         code_1400_ff  <= Code1400Reset;
         strict_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SIGNATURE:  sig_ff        <= csr_wdata[SigWidth-1:0];
            CSR_CODE_BEGIN: code_begin_ff <= csr_wdata[ByteWidth-1:0];
            CSR_CODE_END:   code_end_ff   <= csr_wdata[ByteWidth-1:0];
            CSR_CODE_1200:  code_1200_ff  <= csr_wdata[ByteWidth-1:0];
            CSR_CODE_2400:  code_2400_ff  <= csr_wdata[ByteWidth-1:0];
            CSR_CODE_1400:  code_1400_ff  <= csr_wdata[ByteWidth-1:0];
            CSR_STRICT:     strict_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // payload buffer
   vfd_ram #(
      .Width (ByteWidth),
      .Depth (PayloadMax)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_if.in_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire

// File: design/vfd_ram.sv
`default_nettype none

module vfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/vfd_checker.sv
`default_nettype none

module vfd_checker import vfd_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [ByteWidth-1:0] rsp_out_byte,
   input wire logic                 rsp_last,
   input wire logic [KindWidth-1:0] rsp_kind
);

   // a response waits until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last) && $stable(rsp_kind))
      else $error("stalled response changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // only the three voice kinds are reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_1200 || rsp_kind == KIND_2400 || rsp_kind == KIND_1400))
      else $error("bad voice kind");

   // requests are held off while a frame is still draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken mid frame");

endmodule

bind voice_frame_deframer_core vfd_checker u_vfd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_out_byte (rsp_if.out_byte),
   .rsp_last     (rsp_if.last_of_frame),
   .rsp_kind     (rsp_if.voice_kind)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import vfd_pkg::*;

   // run limits
   localparam int CycleLimit   = 200000;
   localparam int SettleCycles = 20;
   localparam int DrainLimit   = 20000;
   localparam int TailCycles   = 40;
   localparam int LongHold     = 200;
   localparam int PhaseBytes   = 38;

   // one voice byte as it leaves the block
   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 last;
      voice_kind_type       vkind;
   } voice_byte_type;

   // directed table: a raw byte to send, or a voice byte typed in by hand
   typedef enum logic {ROW_BYTE, ROW_RESULT} row_op_type;

   typedef struct packed {
      row_op_type           row_op;
      logic [ByteWidth-1:0] value;
      logic                 last;
      voice_kind_type       vkind;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                    csr_we;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   vfd_req_if req_if ();
   vfd_rsp_if rsp_if ();

   voice_frame_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies seen by the predictor
   logic [SigWidth-1:0]  sig_cfg;
   logic [ByteWidth-1:0] begin_code;
   logic [ByteWidth-1:0] end_code;
   logic [ByteWidth-1:0] code_1200;
   logic [ByteWidth-1:0] code_2400;
   logic [ByteWidth-1:0] code_1400;
   logic                 strict_cfg;

   // deframer state copy
   logic [31:0]          hdr_window;
   logic [2:0]           hdr_fill;
   logic                 collecting;
   logic [2:0]           bytes_left;
   logic [2:0]           frame_len;
   logic [ByteWidth-1:0] frame_buf [SizeV7];
   logic                 stream_open;

   // voice bytes still to come, oldest first
   voice_byte_type voice_expect_q [$];
   // hand-typed voice bytes waiting for the request that completes their frame
   voice_byte_type typed_voice_q [$];
   // voice bytes caused by the latest request
   voice_byte_type burst_q [$];

   int error_count = 0;
   int cycle_count = 0;
   int bytes_sent  = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rsp_hold_cycles = 0;

   // directed part: sliding header into a 2400 frame, an unknown type,
   // then a 1400 frame; payloads hold the byte extremes
   stim_row_type directed_rows [39] = '{
      // junk byte ahead of the header, window slides once
      '{ROW_BYTE, 8'hFF, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h03, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'hFF, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h80, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h7F, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h01, 1'b0, KIND_1200},
      '{ROW_RESULT, 8'h00, 1'b0, KIND_2400},
      '{ROW_RESULT, 8'hFF, 1'b0, KIND_2400},
      '{ROW_RESULT, 8'h80, 1'b0, KIND_2400},
      '{ROW_RESULT, 8'h7F, 1'b0, KIND_2400},
      '{ROW_RESULT, 8'h01, 1'b0, KIND_2400},
      '{ROW_RESULT, 8'hFE, 1'b1, KIND_2400},
      '{ROW_BYTE, 8'hFE, 1'b0, KIND_1200},
      // unknown type, header dropped
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h09, 1'b0, KIND_1200},
      // 1400 frame, seven bytes
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h00, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h04, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'hAA, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h55, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h01, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'hFE, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h10, 1'b0, KIND_1200},
      '{ROW_BYTE, 8'h20, 1'b0, KIND_1200},
      '{ROW_RESULT, 8'hAA, 1'b0, KIND_1400},
      '{ROW_RESULT, 8'h55, 1'b0, KIND_1400},
      '{ROW_RESULT, 8'h01, 1'b0, KIND_1400},
      '{ROW_RESULT, 8'hFE, 1'b0, KIND_1400},
      '{ROW_RESULT, 8'h10, 1'b0, KIND_1400},
      '{ROW_RESULT, 8'h20, 1'b0, KIND_1400},
      '{ROW_RESULT, 8'hFF, 1'b1, KIND_1400},
      '{ROW_BYTE, 8'hFF, 1'b0, KIND_1200}
   };

   // payload length of a type byte, zero when the type is unknown
   // markers win over 1400, 1400 over 1200/2400
   function automatic int payload_size(input logic [ByteWidth-1:0] t);
      if (t == begin_code || t == end_code) return SizeMarker;
      if (t == code_1400) return SizeV7;
      if (t == code_1200 || t == code_2400) return SizeV6;
      return 0;
   endfunction

   // voice test, first match in the order 1200, 2400, 1400
   function automatic logic is_voice(input logic [ByteWidth-1:0] t,
                                     output voice_kind_type k);
      k = KIND_1200;
      if (t == code_1200) return 1'b1;
      k = KIND_2400;
      if (t == code_2400) return 1'b1;
      k = KIND_1400;
      if (t == code_1400) return 1'b1;
      k = KIND_1200;
      return 1'b0;
   endfunction

   // predictor: one stream byte in, the voice bytes it releases into burst_q
   task automatic deframe_byte(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] t;
      voice_kind_type       k;
      logic                 voice;
      logic                 emit;
      int                   size;
      burst_q.delete();
      if (collecting) begin
         frame_buf[frame_len - bytes_left] = b;
         bytes_left = bytes_left - 3'd1;
         if (bytes_left != 0) return;
         collecting = 1'b0;
         t = hdr_window[7:0];
         voice = is_voice(t, k);
         emit = 1'b0;
         if (!strict_cfg) begin
            emit = voice;
         end else if (!stream_open) begin
            // closed stream only looks for the begin marker
            if (t == begin_code) stream_open = 1'b1;
         end else if (voice) begin
            emit = 1'b1;
         end else if (t == end_code) begin
            stream_open = 1'b0;
         end
         if (emit) begin
            for (int i = 0; i < frame_len; i++)
               burst_q.push_back('{data: frame_buf[i], last: (i + 1 == frame_len), vkind: k});
         end
         return;
      end
      hdr_window = {hdr_window[23:0], b};
      hdr_fill = hdr_fill + 3'd1;
      if (hdr_fill < 4) return;
      if (hdr_window[31:8] != sig_cfg) begin
         // no signature, slide by one byte
         hdr_fill = 3'd3;
         return;
      end
      hdr_fill = 3'd0;
      size = payload_size(hdr_window[7:0]);
      if (size == 0) return;
      frame_len  = size[2:0];
      bytes_left = size[2:0];
      collecting = 1'b1;
   endtask

   task automatic check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
         error_count++;
      end
   endtask

   // watch both channels and the register port at every rising edge
   always @(posedge clock) begin : monitor
      voice_byte_type exp;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SIGNATURE:  sig_cfg    = csr_wdata;
               CSR_CODE_BEGIN: begin_code = csr_wdata[ByteWidth-1:0];
               CSR_CODE_END:   end_code   = csr_wdata[ByteWidth-1:0];
               CSR_CODE_1200:  code_1200  = csr_wdata[ByteWidth-1:0];
               CSR_CODE_2400:  code_2400  = csr_wdata[ByteWidth-1:0];
               CSR_CODE_1400:  code_1400  = csr_wdata[ByteWidth-1:0];
               CSR_STRICT:     strict_cfg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            deframe_byte(req_if.in_byte);
            // hand-typed bytes stand in for the predicted burst
            if (typed_voice_q.size() != 0) begin
               foreach (typed_voice_q[i]) voice_expect_q.push_back(typed_voice_q[i]);
               typed_voice_q.delete();
            end else begin
               foreach (burst_q[i]) voice_expect_q.push_back(burst_q[i]);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (voice_expect_q.size() == 0) begin
               $error("unexpected voice byte 0x%0h", rsp_if.out_byte);
               error_count++;
            end else begin
               exp = voice_expect_q.pop_front();
               check_field("out_byte", exp.data, rsp_if.out_byte);
               check_field("last_of_frame", exp.last, rsp_if.last_of_frame);
               check_field("voice_kind", exp.vkind, rsp_if.voice_kind);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random back-pressure, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // one request: optional idle gap, then hold valid until accepted
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // stop sending and let every expected voice byte come out
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (voice_expect_q.size() != 0) @(negedge clock);
      // a frame with no output may still be finishing inside
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // all seven registers, written only once the block has gone quiet
   task automatic configure(input logic [SigWidth-1:0] sig,
                            input logic [ByteWidth-1:0] c_begin,
                            input logic [ByteWidth-1:0] c_end,
                            input logic [ByteWidth-1:0] c_1200,
                            input logic [ByteWidth-1:0] c_2400,
                            input logic [ByteWidth-1:0] c_1400,
                            input logic strict);
      wait_drained();
      write_csr(CSR_SIGNATURE, sig);
      write_csr(CSR_CODE_BEGIN, {16'h0, c_begin});
      write_csr(CSR_CODE_END, {16'h0, c_end});
      write_csr(CSR_CODE_1200, {16'h0, c_1200});
      write_csr(CSR_CODE_2400, {16'h0, c_2400});
      write_csr(CSR_CODE_1400, {16'h0, c_1400});
      write_csr(CSR_STRICT, {23'h0, strict});
      csr_we <= 1'b0;
   endtask

   // type byte of a well-formed frame; strict mode leans on begin/end so
   // the stream opens and closes often
   function automatic logic [ByteWidth-1:0] pick_type();
      int roll;
      roll = $urandom_range(99);
      if (strict_cfg && roll < 20) return begin_code;
      if (strict_cfg && roll < 35) return end_code;
      if (!strict_cfg && roll < 15) return roll[0] ? begin_code : end_code;
      case ($urandom_range(2))
         0:       return code_1200;
         1:       return code_2400;
         default: return code_1400;
      endcase
   endfunction

   // mostly well-formed frames with random payload, then unknown types,
   // broken signatures and loose noise
   task automatic send_random_frame();
      int                   roll;
      int                   len;
      logic [ByteWidth-1:0] frame_type;
      logic [SigWidth-1:0]  hdr;
      roll = $urandom_range(99);
      hdr  = sig_cfg;
      if (roll >= 94) begin
         len = $urandom_range(6, 1);
         repeat (len) send_byte(ByteWidth'($urandom_range(255)));
      end else begin
         if (roll >= 88) hdr[8*$urandom_range(2) +: 8] ^= ByteWidth'($urandom_range(255, 1));
         frame_type = (roll < 78) ? pick_type() : ByteWidth'($urandom_range(255));
         send_byte(hdr[23:16]);
         send_byte(hdr[15:8]);
         send_byte(hdr[7:0]);
         send_byte(frame_type);
         len = (roll >= 88) ? $urandom_range(7) : payload_size(frame_type);
         repeat (len) send_byte(ByteWidth'($urandom_range(255)));
      end
   endtask

   task automatic run_frames(input int n_bytes);
      int target;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) send_random_frame();
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_SIGNATURE;
      csr_wdata      = '0;

      // register reset values
      sig_cfg    = SigReset;
      begin_code = CodeBeginReset;
      end_code   = CodeEndReset;
      code_1200  = Code1200Reset;
      code_2400  = Code2400Reset;
      code_1400  = Code1400Reset;
      strict_cfg = 1'b0;

      // deframer state after reset
      hdr_window  = '0;
      hdr_fill    = '0;
      collecting  = 1'b0;
      bytes_left  = '0;
      frame_len   = '0;
      stream_open = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // eager sender, busy receiver
      tx_idle_pct = 17;
      rx_idle_pct = 86;

      // directed table on the reset settings
      foreach (directed_rows[i]) begin
         if (directed_rows[i].row_op == ROW_BYTE)
            send_byte(directed_rows[i].value);
         else
            typed_voice_q.push_back('{data: directed_rows[i].value,
                                      last: directed_rows[i].last,
                                      vkind: directed_rows[i].vkind});
      end

      // distinct codes around a random base, loose mode
      begin : loose_random_codes
         logic [ByteWidth-1:0] base;
         base = ByteWidth'($urandom_range(251));
         configure(SigWidth'($urandom_range(24'hFFFFFF)), base, base + 8'd1, base + 8'd2,
                   base + 8'd3, base + 8'd4, 1'b0);
      end
      // receiver holds off long enough for the block to stall its input
      @(posedge clock);
      rsp_hold_cycles = LongHold;
      @(negedge clock);
      run_frames(PhaseBytes);

      // all-ones signature, extreme codes, strict mode
      configure(24'hFFFFFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 1'b1);
      run_frames(PhaseBytes);

      // slow sender, light back-pressure
      tx_idle_pct = 86;
      rx_idle_pct = 17;

      // strict mode with markers that are also voice codes
      configure(24'h000000, 8'h05, 8'h06, 8'h05, 8'h07, 8'h06, 1'b1);
      run_frames(PhaseBytes / 2);
      // sender pauses until everything has come out
      req_if.valid <= 1'b0;
      while (voice_expect_q.size() != 0) @(negedge clock);
      @(negedge clock);
      run_frames(PhaseBytes - PhaseBytes / 2);

      // 2400 and 1400 share a code: seven bytes tagged 2400
      configure(SigWidth'($urandom_range(24'hFFFFFF)), 8'h0A, 8'h0B, 8'h14, 8'h1E, 8'h1E,
                1'b0);
      run_frames(PhaseBytes);

      // no idling at all
      tx_idle_pct = 0;
      rx_idle_pct = 0;

      // fully random codes, overlaps allowed
      configure(SigWidth'($urandom_range(24'hFFFFFF)), ByteWidth'($urandom_range(255)),
                ByteWidth'($urandom_range(255)), ByteWidth'($urandom_range(255)),
                ByteWidth'($urandom_range(255)), ByteWidth'($urandom_range(255)),
                1'($urandom_range(1)));
      run_frames(PhaseBytes);

      // zero signature, 1200 and 2400 overlap, end marker doubles as 1400
      configure(24'h000000, 8'h00, 8'hFF, 8'h40, 8'h40, 8'hFF, 1'b0);
      run_frames(PhaseBytes);

      // drain, then let any stray output show up
      req_if.valid <= 1'b0;
      begin : final_drain
         int waited;
         waited = 0;
         while (voice_expect_q.size() != 0 && waited < DrainLimit) begin
            @(negedge clock);
            waited++;
         end
      end
      repeat (TailCycles) @(negedge clock);
      if (voice_expect_q.size() != 0) begin
         $error("%0d voice bytes never came out", voice_expect_q.size());
         error_count++;
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
